@@ hw/rtl/avcab_pkg.sv @@
package avcab_pkg;

  // start code: (START_CODE_BYTES-1) zero bytes, then 0x01
  localparam int START_CODE_BYTES = 4;
  localparam int SC_IDX_W = (START_CODE_BYTES > 1) ? $clog2(START_CODE_BYTES) : 1;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam int LFB_W = 3;
  localparam logic [LFB_W-1:0] LFB_RESET = 3'd4;
  localparam logic [LFB_W-1:0] LFB_MIN   = 3'd1;
  localparam logic [LFB_W-1:0] LFB_MAX   = 3'd4;

  // configuration register byte addresses
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_LENGTH_FIELD_BYTES = 3'd0;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_LEN  = 2'd1,
    ST_TRUNC_LEN = 2'd2,
    ST_TRUNC_PAY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_BYTE   = 2'd0,  // pass one payload byte
    CMD_START  = 2'd1,  // expand into a start code
    CMD_STATUS = 2'd2   // status-only word closing the unit
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       unit_end;
    status_t    status;
  } cmd_t;

endpackage

@@ hw/rtl/avcab_front.sv @@
module avcab_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [7:0]                     data_byte,
  input  logic                           unit_last,
  input  logic [avcab_pkg::LFB_W-1:0]    length_field_bytes,
  output logic                           cmd_valid,
  output avcab_pkg::cmd_t                cmd
);

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_PAY  = 2'd1,
    PH_DISC = 2'd2
  } phase_t;

  phase_t                       phase, phase_next;
  logic [31:0]                  acc, acc_next;
  logic [2:0]                   seen, seen_next;
  logic [31:0]                  rem, rem_next;
  avcab_pkg::status_t           err, err_next;

  logic [avcab_pkg::LFB_W-1:0]  lfb;
  logic [31:0]                  acc_shift;
  logic [2:0]                   seen_inc;
  logic [31:0]                  rem_dec;

  always_comb begin
    if (length_field_bytes < avcab_pkg::LFB_MIN) begin
      lfb = avcab_pkg::LFB_MIN;
    end else if (length_field_bytes > avcab_pkg::LFB_MAX) begin
      lfb = avcab_pkg::LFB_MAX;
    end else begin
      lfb = length_field_bytes;
    end
  end

  assign acc_shift = {acc[23:0], data_byte};
  assign seen_inc  = seen + 3'd1;
  assign rem_dec   = rem - 32'd1;

  always_comb begin
    phase_next   = phase;
    acc_next     = acc;
    seen_next    = seen;
    rem_next     = rem;
    err_next     = err;
    cmd_valid    = 1'b0;
    cmd.kind     = avcab_pkg::CMD_STATUS;
    cmd.data     = data_byte;
    cmd.unit_end = 1'b1;
    cmd.status   = avcab_pkg::ST_OK;

    unique case (phase)
      PH_LEN: begin
        if (seen_inc >= lfb) begin
          if (acc_shift == 32'd0) begin
            err_next   = avcab_pkg::ST_ZERO_LEN;
            phase_next = PH_DISC;
            cmd_valid  = unit_last;
            cmd.status = avcab_pkg::ST_ZERO_LEN;
          end else if (unit_last) begin
            cmd_valid  = 1'b1;
            cmd.status = avcab_pkg::ST_TRUNC_PAY;
          end else begin
            cmd_valid    = 1'b1;
            cmd.kind     = avcab_pkg::CMD_START;
            cmd.unit_end = 1'b0;
            rem_next     = acc_shift;
            acc_next     = 32'd0;
            seen_next    = 3'd0;
            phase_next   = PH_PAY;
          end
        end else begin
          acc_next   = acc_shift;
          seen_next  = seen_inc;
          cmd_valid  = unit_last;
          cmd.status = avcab_pkg::ST_TRUNC_LEN;
        end
      end
      PH_PAY: begin
        rem_next     = rem_dec;
        cmd_valid    = 1'b1;
        cmd.kind     = avcab_pkg::CMD_BYTE;
        cmd.unit_end = unit_last;
        if (unit_last && rem_dec != 32'd0) begin
          cmd.status = avcab_pkg::ST_TRUNC_PAY;
        end
        if (rem_dec == 32'd0) begin
          phase_next = PH_LEN;
        end
      end
      PH_DISC: begin
        cmd_valid  = unit_last;
        cmd.status = err;
      end
      default: begin
        phase_next = PH_LEN;
      end
    endcase

    // end of access unit: back to a clean state
    if (unit_last) begin
      phase_next = PH_LEN;
      acc_next   = 32'd0;
      seen_next  = 3'd0;
      rem_next   = 32'd0;
      err_next   = avcab_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LEN;
      acc   <= 32'd0;
      seen  <= 3'd0;
      rem   <= 32'd0;
      err   <= avcab_pkg::ST_OK;
    end else if (accept) begin
      phase <= phase_next;
      acc   <= acc_next;
      seen  <= seen_next;
      rem   <= rem_next;
      err   <= err_next;
    end
  end

  // payload phase always has bytes left to pass
  a_pay_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAY) |-> (rem != 32'd0))
    else $error("payload phase with zero remaining");

  // discarding only follows a zero length
  a_disc_err: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DISC) |-> (err == avcab_pkg::ST_ZERO_LEN))
    else $error("discard phase without error code");

endmodule

@@ hw/rtl/avcab_cmd_fifo.sv @@
module avcab_cmd_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  avcab_pkg::cmd_t  wr_cmd,
  output logic             full,
  input  logic             rd_en,
  output logic             not_empty,
  output avcab_pkg::cmd_t  rd_cmd
);

  avcab_pkg::cmd_t                    mem [avcab_pkg::CMDQ_DEPTH];
  logic [avcab_pkg::CMDQ_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [avcab_pkg::CMDQ_CNT_W-1:0]   count;

  assign full      = (count == avcab_pkg::CMDQ_CNT_W'(avcab_pkg::CMDQ_DEPTH));
  assign not_empty = (count != '0);
  assign rd_cmd    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> not_empty)
    else $error("command queue read while empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full)
    else $error("command queue written while full");

endmodule

@@ hw/rtl/avcab_back.sv @@
module avcab_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_avail,
  input  avcab_pkg::cmd_t  cmd,
  output logic             cmd_take,
  input  logic             pop,
  output logic             empty,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic             run_last,
  output logic             unit_end,
  output logic [1:0]       status
);

  localparam logic [avcab_pkg::SC_IDX_W-1:0] SC_LAST =
    avcab_pkg::SC_IDX_W'(avcab_pkg::START_CODE_BYTES - 1);

  logic                            out_valid;
  logic [avcab_pkg::SC_IDX_W-1:0]  sc_idx;
  logic                            advance;
  logic                            load;
  logic                            sc_done;

  assign empty   = !out_valid;
  assign advance = !out_valid || pop;
  assign load    = advance && cmd_avail;
  assign sc_done = (sc_idx == SC_LAST);
  assign cmd_take = load && ((cmd.kind != avcab_pkg::CMD_START) || sc_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sc_idx    <= '0;
    end else if (advance) begin
      out_valid <= cmd_avail;
      if (load && cmd.kind == avcab_pkg::CMD_START) begin
        sc_idx <= sc_done ? '0 : sc_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unique case (cmd.kind)
        avcab_pkg::CMD_START: begin
          out_byte   <= sc_done ? 8'h01 : 8'h00;
          byte_valid <= 1'b1;
          run_last   <= sc_done;
          unit_end   <= 1'b0;
          status     <= 2'(avcab_pkg::ST_OK);
        end
        avcab_pkg::CMD_BYTE: begin
          out_byte   <= cmd.data;
          byte_valid <= 1'b1;
          run_last   <= 1'b1;
          unit_end   <= cmd.unit_end;
          status     <= 2'(cmd.status);
        end
        default: begin
          out_byte   <= 8'h00;
          byte_valid <= 1'b0;
          run_last   <= 1'b1;
          unit_end   <= 1'b1;
          status     <= 2'(cmd.status);
        end
      endcase
    end
  end

  // mid start code the head command must stay a start command
  a_sc_head: assert property (@(posedge clk) disable iff (rst)
    (sc_idx != '0) |-> (cmd_avail && cmd.kind == avcab_pkg::CMD_START))
    else $error("start code counter running without start command");

endmodule

@@ hw/rtl/avc_length_prefixed_to_annexb_core.sv @@
// Channel   Dir  Handshake            Word
// -------   ---  -------------------  --------------------------------------------
// input     in   push / full          data_byte, unit_last
// result    out  pop / empty          out_byte, byte_valid, run_last, unit_end, status
// config    in   APB psel/penable     length_field_bytes at byte address 0
//
// One input word per cycle unless full; payload bytes are queued, then loaded as results.
// A non-zero length field yields a 4-word start code, drained one word per cycle by
// the back end unless held; a 4-entry command queue absorbs it, then full pushes back.
// Words that cause no result (length bytes, discarded bytes) only update state.
// rst is synchronous, active high: queue empty, unit state cleared, register = 4.
// The result register holds while empty is low and pop is low.
module avc_length_prefixed_to_annexb_core (
  input  logic                                 clk,
  input  logic                                 rst,
  // input queue side
  input  logic                                 push,
  output logic                                 full,
  input  logic [7:0]                           data_byte,
  input  logic                                 unit_last,
  // result queue side
  input  logic                                 pop,
  output logic                                 empty,
  output logic [7:0]                           out_byte,
  output logic                                 byte_valid,
  output logic                                 run_last,
  output logic                                 unit_end,
  output logic [1:0]                           status,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [avcab_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  logic [avcab_pkg::LFB_W-1:0] length_field_bytes;
  logic                        in_accept;
  logic                        cmd_valid;
  avcab_pkg::cmd_t             front_cmd;
  logic                        q_not_empty;
  avcab_pkg::cmd_t             q_cmd;
  logic                        q_take;

  // --- configuration register ---
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_field_bytes <= avcab_pkg::LFB_RESET;
    end else if (psel && penable && pwrite && paddr == avcab_pkg::ADDR_LENGTH_FIELD_BYTES) begin
      length_field_bytes <= pwdata[avcab_pkg::LFB_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == avcab_pkg::ADDR_LENGTH_FIELD_BYTES) begin
      prdata = 32'(length_field_bytes);
    end
  end

  // --- front: parse length fields, classify each input word ---
  assign in_accept = push && !full;

  avcab_front u_front (
    .clk                (clk),
    .rst                (rst),
    .accept             (in_accept),
    .data_byte          (data_byte),
    .unit_last          (unit_last),
    .length_field_bytes (length_field_bytes),
    .cmd_valid          (cmd_valid),
    .cmd                (front_cmd)
  );

  // --- command queue between front and back ---
  avcab_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (in_accept && cmd_valid),
    .wr_cmd    (front_cmd),
    .full      (full),
    .rd_en     (q_take),
    .not_empty (q_not_empty),
    .rd_cmd    (q_cmd)
  );

  // --- back: expand start codes, hold the result register ---
  avcab_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_avail  (q_not_empty),
    .cmd        (q_cmd),
    .cmd_take   (q_take),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .run_last   (run_last),
    .unit_end   (unit_end),
    .status     (status)
  );

endmodule
